@@ design/fcb_pkg.sv @@
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types and constants of the frustum cull block.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int COEF_W    = 17;  // sum of two Q4.12 entries
  localparam int ENTRY_W   = 16;
  localparam int ROW_W     = 64;
  localparam int RADIUS_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_PLANE = 6;
  localparam int POS_FRAC  = 8;   // d term is scaled by 2^8 to match Q.20

  typedef enum logic [2:0] {
    PLANE_LEFT   = 3'd0,
    PLANE_RIGHT  = 3'd1,
    PLANE_BOTTOM = 3'd2,
    PLANE_TOP    = 3'd3,
    PLANE_NEAR   = 3'd4,
    PLANE_FAR    = 3'd5,
    PLANE_NONE   = 3'd6
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ZERO  = 3'd0,
    REG_ROW_ONE   = 3'd1,
    REG_ROW_TWO   = 3'd2,
    REG_ROW_THREE = 3'd3,
    REG_RADIUS    = 3'd4
  } cfg_reg_e;

  localparam logic [ROW_W-1:0]    ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0]    ROW_ONE_RST   = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0]    ROW_TWO_RST   = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0]    ROW_THREE_RST = 64'h1000_0000_0000_0000;
  localparam logic [RADIUS_W-1:0] RADIUS_RST    = 16'd384;

  // Control that travels along the cell chain with each request
  typedef struct packed {
    logic   valid;
    plane_e reject;
  } cell_ctl_t;

endpackage

@@ design/fcb_if.sv @@
// ----------------------------------------------------------------------------
// fcb interfaces
// Node request, cull response and configuration write channels.
// ----------------------------------------------------------------------------
interface fcb_node_if #(
  parameter int ID_WIDTH    = 16,
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic        [ID_WIDTH-1:0]    node_id;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, node_id, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, node_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface fcb_rsp_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] result_id;
  logic                visible;
  logic [2:0]          rejecting_plane;

  modport source (output valid, result_id, visible, rejecting_plane, input ready);
  modport sink   (input valid, result_id, visible, rejecting_plane, output ready);
endinterface

interface fcb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/frustum_cull_bounding_box_core.sv @@
// Pipeline: a request passes the corner stage and then two register stages in each of
//   six plane cells before the response is valid; back-pressure can stall it.
// Throughput: one request per cycle while responses are taken; each plane cell is a
//   two-stage pipeline and any empty stage takes a new request while the output waits.
// Reset: clears all valid bits, loads the identity matrix and radius 1.5.
// ----------------------------------------------------------------------------
// frustum_cull_bounding_box_core
// Tests a cube around a node position against six view-projection planes.
// ----------------------------------------------------------------------------
module frustum_cull_bounding_box_core #(
  parameter int COORD_WIDTH = 24,
  parameter int ID_WIDTH    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcb_node_if.sink  node_i,
  fcb_rsp_if.source rsp_o,
  fcb_cfg_if.sink   cfg_i
);
  import fcb_pkg::*;

  localparam int CW = COORD_WIDTH + 2;  // corner = position +/- radius

  logic [ROW_W-1:0]    row_q [4];
  logic [RADIUS_W-1:0] radius_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_ZERO_RST;
      row_q[1] <= ROW_ONE_RST;
      row_q[2] <= ROW_TWO_RST;
      row_q[3] <= ROW_THREE_RST;
      radius_q <= RADIUS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ROW_ZERO:  row_q[0] <= cfg_i.data;
        REG_ROW_ONE:   row_q[1] <= cfg_i.data;
        REG_ROW_TWO:   row_q[2] <= cfg_i.data;
        REG_ROW_THREE: row_q[3] <= cfg_i.data;
        REG_RADIUS:    radius_q <= cfg_i.data[RADIUS_W-1:0];
        default:       ;
      endcase
    end
  end

  cell_ctl_t            ctl   [NUM_PLANE+1];
  logic                 ready [NUM_PLANE+1];
  logic [ID_WIDTH-1:0]  id    [NUM_PLANE+1];
  logic signed [CW-1:0] lo    [NUM_PLANE+1][3];
  logic signed [CW-1:0] hi    [NUM_PLANE+1][3];
  logic signed [COORD_WIDTH-1:0] pos [3];

  assign pos[0] = node_i.pos_x;
  assign pos[1] = node_i.pos_y;
  assign pos[2] = node_i.pos_z;

  fcb_corner_stage #(
    .ID_WIDTH    (ID_WIDTH),
    .COORD_WIDTH (COORD_WIDTH),
    .CW          (CW)
  ) u_corner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (node_i.valid),
    .up_ready_o (node_i.ready),
    .id_i       (node_i.node_id),
    .pos_i      (pos),
    .radius_i   (radius_q),
    .dn_ctl_o   (ctl[0]),
    .dn_ready_i (ready[0]),
    .id_o       (id[0]),
    .lo_o       (lo[0]),
    .hi_o       (hi[0])
  );

  for (genvar p = 0; p < NUM_PLANE; p++) begin : g_cell
    fcb_plane_cell #(
      .ID_WIDTH (ID_WIDTH),
      .CW       (CW),
      .PLANE    (p)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .row_i      (row_q[p/2]),
      .base_i     (row_q[3]),
      .up_ctl_i   (ctl[p]),
      .up_ready_o (ready[p]),
      .id_i       (id[p]),
      .lo_i       (lo[p]),
      .hi_i       (hi[p]),
      .dn_ctl_o   (ctl[p+1]),
      .dn_ready_i (ready[p+1]),
      .id_o       (id[p+1]),
      .lo_o       (lo[p+1]),
      .hi_o       (hi[p+1])
    );
  end

  assign ready[NUM_PLANE]     = rsp_o.ready;
  assign rsp_o.valid          = ctl[NUM_PLANE].valid;
  assign rsp_o.result_id      = id[NUM_PLANE];
  assign rsp_o.rejecting_plane = ctl[NUM_PLANE].reject;
  assign rsp_o.visible        = (ctl[NUM_PLANE].reject == PLANE_NONE);

  a_visible_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.visible |-> rsp_o.rejecting_plane == PLANE_NONE)
    else $error("visible response carries a rejecting plane");

  a_plane_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.rejecting_plane <= PLANE_NONE)
    else $error("rejecting plane code out of range");

  a_radius_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.index == REG_RADIUS |=>
      radius_q == $past(cfg_i.data[RADIUS_W-1:0]))
    else $error("radius write not taken");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl[0].valid && !ready[0] |=> ctl[0].valid && id[0] == $past(id[0]))
    else $error("corner stage lost a request under stall");

endmodule

@@ design/fcb_corner_stage.sv @@
// ----------------------------------------------------------------------------
// fcb_corner_stage
// Registers a request and forms the min and max box corners per axis.
// ----------------------------------------------------------------------------
module fcb_corner_stage #(
  parameter int ID_WIDTH    = 16,
  parameter int COORD_WIDTH = 24,
  parameter int CW          = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          up_valid_i,
  output logic                          up_ready_o,
  input  logic        [ID_WIDTH-1:0]    id_i,
  input  logic signed [COORD_WIDTH-1:0] pos_i [3],
  input  logic        [15:0]            radius_i,
  output fcb_pkg::cell_ctl_t            dn_ctl_o,
  input  logic                          dn_ready_i,
  output logic        [ID_WIDTH-1:0]    id_o,
  output logic signed [CW-1:0]          lo_o [3],
  output logic signed [CW-1:0]          hi_o [3]
);
  import fcb_pkg::*;

  logic                valid_q;
  logic [ID_WIDTH-1:0] id_q;
  logic signed [CW-1:0] lo_q [3];
  logic signed [CW-1:0] hi_q [3];
  logic signed [CW-1:0] lo_d [3];
  logic signed [CW-1:0] hi_d [3];
  logic signed [CW-1:0] rad_ext;
  logic                 load;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign load       = up_valid_i && up_ready_o;
  assign rad_ext    = $signed({{(CW-RADIUS_W){1'b0}}, radius_i});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_d[k] = CW'(pos_i[k]) - rad_ext;
      hi_d[k] = CW'(pos_i[k]) + rad_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q <= id_i;
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign dn_ctl_o.valid  = valid_q;
  assign dn_ctl_o.reject = PLANE_NONE;
  assign id_o            = id_q;
  assign lo_o            = lo_q;
  assign hi_o            = hi_q;

endmodule

@@ design/fcb_plane_cell.sv @@
// ----------------------------------------------------------------------------
// fcb_plane_cell
// One frustum plane: holds its coefficients, multiplies, sums and tests.
// ----------------------------------------------------------------------------
module fcb_plane_cell #(
  parameter int ID_WIDTH = 16,
  parameter int CW       = 26,
  parameter int PLANE    = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fcb_pkg::ROW_W-1:0]  row_i,
  input  logic [fcb_pkg::ROW_W-1:0]  base_i,
  input  fcb_pkg::cell_ctl_t         up_ctl_i,
  output logic                       up_ready_o,
  input  logic        [ID_WIDTH-1:0] id_i,
  input  logic signed [CW-1:0]       lo_i [3],
  input  logic signed [CW-1:0]       hi_i [3],
  output fcb_pkg::cell_ctl_t         dn_ctl_o,
  input  logic                       dn_ready_i,
  output logic        [ID_WIDTH-1:0] id_o,
  output logic signed [CW-1:0]       lo_o [3],
  output logic signed [CW-1:0]       hi_o [3]
);
  import fcb_pkg::*;

  localparam int PW = COEF_W + CW;
  localparam int SW = PW + 2;
  localparam logic SUBTRACT = (PLANE % 2) == 1;
  localparam plane_e MY_PLANE = plane_e'(PLANE);

  // plane coefficients, refreshed from the matrix every cycle
  logic signed [COEF_W-1:0] coef_q [4];
  logic signed [COEF_W-1:0] coef_d [4];

  // stage A: products
  cell_ctl_t            a_ctl_q;
  logic [ID_WIDTH-1:0]  a_id_q;
  logic signed [CW-1:0] a_lo_q [3];
  logic signed [CW-1:0] a_hi_q [3];
  logic signed [PW-1:0] prod_q [4];
  logic signed [PW-1:0] prod_d [4];
  logic                 a_ready;

  // stage B: plane verdict
  cell_ctl_t            b_ctl_q;
  cell_ctl_t            b_ctl_d;
  logic [ID_WIDTH-1:0]  b_id_q;
  logic signed [CW-1:0] b_lo_q [3];
  logic signed [CW-1:0] b_hi_q [3];
  logic signed [SW-1:0] sum;
  logic                 b_ready;

  always_comb begin
    logic signed [ENTRY_W-1:0] e_base;
    logic signed [ENTRY_W-1:0] e_row;
    for (int k = 0; k < 4; k++) begin
      e_base = $signed(base_i[ENTRY_W*k +: ENTRY_W]);
      e_row  = $signed(row_i[ENTRY_W*k +: ENTRY_W]);
      if (SUBTRACT) begin
        coef_d[k] = COEF_W'(e_base) - COEF_W'(e_row);
      end else begin
        coef_d[k] = COEF_W'(e_base) + COEF_W'(e_row);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  // most-positive corner: max where the coefficient is strictly positive
  always_comb begin
    logic signed [CW-1:0] corner;
    for (int k = 0; k < 3; k++) begin
      corner = (!coef_q[k][COEF_W-1] && (coef_q[k] != '0)) ? hi_i[k] : lo_i[k];
      prod_d[k] = PW'(coef_q[k]) * PW'(corner);
    end
    prod_d[3] = $signed({{(PW-COEF_W-POS_FRAC){coef_q[3][COEF_W-1]}}, coef_q[3],
                         {POS_FRAC{1'b0}}});
  end

  assign b_ready    = !b_ctl_q.valid || dn_ready_i;
  assign a_ready    = !a_ctl_q.valid || b_ready;
  assign up_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '{valid: 1'b0, reject: PLANE_NONE};
    end else if (a_ready) begin
      a_ctl_q.valid <= up_ctl_i.valid;
      if (up_ctl_i.valid) begin
        a_ctl_q.reject <= up_ctl_i.reject;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && up_ctl_i.valid) begin
      a_id_q <= id_i;
      a_lo_q <= lo_i;
      a_hi_q <= hi_i;
      prod_q <= prod_d;
    end
  end

  assign sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);

  always_comb begin
    b_ctl_d = a_ctl_q;
    if (a_ctl_q.reject == PLANE_NONE && sum[SW-1]) begin
      b_ctl_d.reject = MY_PLANE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctl_q <= '{valid: 1'b0, reject: PLANE_NONE};
    end else if (b_ready) begin
      b_ctl_q.valid <= a_ctl_q.valid;
      if (a_ctl_q.valid) begin
        b_ctl_q.reject <= b_ctl_d.reject;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_ctl_q.valid) begin
      b_id_q <= a_id_q;
      b_lo_q <= a_lo_q;
      b_hi_q <= a_hi_q;
    end
  end

  assign dn_ctl_o = b_ctl_q;
  assign id_o     = b_id_q;
  assign lo_o     = b_lo_q;
  assign hi_o     = b_hi_q;

endmodule
